// ===== rtl/core/mi3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// shared constants for the 3x3 fixed-point matrix inverse
// ----------------------------------------------------------------------------
package mi3_pkg;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int THR_WIDTH      = 31;
    localparam int NUM_ELEMS      = 9;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = 2;
endpackage

// ===== rtl/core/matrix_inverse_3x3_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top
// 3x3 signed fixed-point matrix inverse by the adjugate
// ----------------------------------------------------------------------------
// One matrix is accepted per clock and one inverse leaves per clock when the
// output is not stalled. A matrix passes the cofactor and determinant
// stages, the queue, then ELEM_WIDTH+3 stages of the bit-per-stage dividers
// plus an output register.
module matrix_inverse_3x3_top #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mi3_pkg::THR_WIDTH-1:0] i_singular_threshold,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [ELEM_WIDTH-1:0]  i_m00, i_m01, i_m02,
    input  logic signed [ELEM_WIDTH-1:0]  i_m10, i_m11, i_m12,
    input  logic signed [ELEM_WIDTH-1:0]  i_m20, i_m21, i_m22,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [ELEM_WIDTH-1:0]  o_r00, o_r01, o_r02,
    output logic signed [ELEM_WIDTH-1:0]  o_r10, o_r11, o_r12,
    output logic signed [ELEM_WIDTH-1:0]  o_r20, o_r21, o_r22,
    output logic                          o_singular
);
    import mi3_pkg::*;
    localparam int CW = 2 * ELEM_WIDTH + 2;
    localparam int DW = 3 * ELEM_WIDTH + 4;
    localparam int QW = 9 * CW + DW + 1;

    logic [THR_WIDTH-1:0]         r_thr;
    logic signed [ELEM_WIDTH-1:0] w_m [9];
    logic signed [CW-1:0]         w_fc [9], w_bc [9];
    logic signed [DW-1:0]         w_fd, w_bd;
    logic                         w_fs, w_bs;
    logic                         w_fv, w_fr, w_qv, w_qr;
    logic [QW-1:0]                w_qi, w_qo;
    logic signed [ELEM_WIDTH-1:0] w_r [9];

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thr <= '0;
        else if (i_cfg_valid) r_thr <= i_singular_threshold;
    end

    assign w_m = '{i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22};

    mi3_front #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_m(w_m), .i_thr(r_thr),
        .o_valid(w_fv), .i_ready(w_fr), .o_cof(w_fc), .o_det(w_fd), .o_sing(w_fs)
    );

    assign w_qi = {w_fc[0], w_fc[1], w_fc[2], w_fc[3], w_fc[4], w_fc[5],
                   w_fc[6], w_fc[7], w_fc[8], w_fd, w_fs};
    assign {w_bc[0], w_bc[1], w_bc[2], w_bc[3], w_bc[4], w_bc[5],
            w_bc[6], w_bc[7], w_bc[8], w_bd, w_bs} = w_qo;

    mi3_queue #(.DATA_W(QW)) u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_data(w_qi),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qo)
    );

    mi3_back #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_cof(w_bc),
        .i_det(w_bd), .i_sing(w_bs), .o_valid, .i_ready, .o_r(w_r),
        .o_sing(o_singular)
    );

    assign {o_r00, o_r01, o_r02} = {w_r[0], w_r[1], w_r[2]};
    assign {o_r10, o_r11, o_r12} = {w_r[3], w_r[4], w_r[5]};
    assign {o_r20, o_r21, o_r22} = {w_r[6], w_r[7], w_r[8]};

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_r00 == '0 && o_r11 == '0 && o_r22 == '0)
        else $error("singular item with nonzero result");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_r00) && $stable(o_singular))
        else $error("stalled item changed");
    a_thr_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_thr == '0)
        else $error("threshold not cleared");
endmodule

// ===== rtl/core/mi3_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_front
// cofactor and determinant pipeline with singular classification
// ----------------------------------------------------------------------------
module mi3_front #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [ELEM_WIDTH-1:0]  i_m [9],
    input  logic [mi3_pkg::THR_WIDTH-1:0] i_thr,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [2*ELEM_WIDTH+1:0] o_cof [9],
    output logic signed [3*ELEM_WIDTH+3:0] o_det,
    output logic                          o_sing
);
    import mi3_pkg::*;
    localparam int PW = 2 * ELEM_WIDTH;
    localparam int CW = 2 * ELEM_WIDTH + 2;
    localparam int DW = 3 * ELEM_WIDTH + 4;

    logic                         r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [ELEM_WIDTH-1:0] r_m1 [9];
    logic signed [PW-1:0]         r_p  [18];
    logic signed [ELEM_WIDTH-1:0] r_m2 [3];
    logic signed [ELEM_WIDTH-1:0] r_m3 [3];
    logic signed [CW-1:0]         r_c3 [9];
    logic signed [CW-1:0]         r_ph [3];
    logic signed [CW-2:0]         r_pl [3];
    logic signed [CW-1:0]         r_c4 [9];
    logic signed [DW-1:0]         r_det;
    logic signed [CW-1:0]         r_c5 [9];
    logic signed [DW-1:0]         w_abs;
    logic [DW-1:0]                w_lim;
    logic                         w_adv;

    // cofactor operand indices a*b - c*d
    localparam int IA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int IB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int IC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int ID [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    assign w_adv   = !r_v5 || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1 <= i_m;
            for (int k = 0; k < 9; k++) begin
                r_p[2*k]   <= r_m1[IA[k]] * r_m1[IB[k]];
                r_p[2*k+1] <= r_m1[IC[k]] * r_m1[ID[k]];
            end
            r_m2 <= '{r_m1[0], r_m1[1], r_m1[2]};
            for (int k = 0; k < 9; k++)
                r_c3[k] <= CW'(r_p[2*k]) - CW'(r_p[2*k+1]);
            r_m3 <= r_m2;
            // first-row terms split into high and low cofactor halves
            for (int j = 0; j < 3; j++) begin
                r_ph[j] <= r_m3[j] * $signed(r_c3[3*j][CW-1:ELEM_WIDTH]);
                r_pl[j] <= r_m3[j] * $signed({1'b0, r_c3[3*j][ELEM_WIDTH-1:0]});
            end
            r_c4  <= r_c3;
            r_det <= ((DW'(r_ph[0]) + DW'(r_ph[1]) + DW'(r_ph[2])) <<< ELEM_WIDTH)
                     + DW'(r_pl[0]) + DW'(r_pl[1]) + DW'(r_pl[2]);
            r_c5  <= r_c4;
        end
    end

    assign w_abs  = r_det[DW-1] ? -r_det : r_det;
    assign w_lim  = DW'(i_thr) << (2 * FRAC_BITS);
    assign o_det  = r_det;
    assign o_cof  = r_c5;
    assign o_sing = $unsigned(w_abs) <= w_lim;
endmodule

// ===== rtl/core/mi3_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_queue
// short fifo between classification and division
// ----------------------------------------------------------------------------
module mi3_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);
    import mi3_pkg::*;
    logic [DATA_W-1:0]   r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic                w_wr, w_rd;

    assign o_ready = r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(w_wr) - (QUEUE_AW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== rtl/core/mi3_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_back
// nine pipelined restoring dividers, one quotient bit per stage, rounding and saturation
// ----------------------------------------------------------------------------
module mi3_back #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [2*ELEM_WIDTH+1:0] i_cof [9],
    input  logic signed [3*ELEM_WIDTH+3:0] i_det,
    input  logic                           i_sing,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [ELEM_WIDTH-1:0]   o_r [9],
    output logic                           o_sing
);
    import mi3_pkg::*;
    localparam int CW = 2 * ELEM_WIDTH + 2;
    localparam int DW = 3 * ELEM_WIDTH + 4;
    // quotient bits: result fits W+1 bits before saturation, plus one guard
    localparam int QB = ELEM_WIDTH + 2;
    // numerator 2*|c|*2^2F + |d|, as wide as needed
    localparam int NW = DW + 2 * FRAC_BITS + 2;
    localparam int RW = DW + 2;
    localparam int NS = QB + 1;

    logic              r_v   [NS];
    logic              r_sg  [NS];
    logic              r_ng  [NS][9];
    logic [QB-1:0]     r_num [NS][9];
    logic [RW-1:0]     r_rem [NS][9];
    logic [QB-1:0]     r_q   [NS][9];
    logic [RW-1:0]     r_dv  [NS];
    logic              r_ovf [NS][9];
    logic              r_ov;
    logic              r_os;
    logic signed [ELEM_WIDTH-1:0] r_or [9];
    logic              w_adv;
    logic [DW-1:0]     w_dm;

    assign w_adv   = !r_ov || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_ov;
    assign o_r     = r_or;
    assign o_sing  = r_os;
    assign w_dm    = i_det[DW-1] ? DW'(-i_det) : DW'(i_det);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_v[s] <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < NS; s++) r_v[s] <= r_v[s-1];
            r_ov <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [RW-1:0] t;
        logic [NW-1:0] nn;
        logic [NW-1:0] top;
        logic [CW-1:0] cm;
        if (w_adv) begin
            r_sg[0] <= i_sing;
            r_dv[0] <= RW'(w_dm) << 1;
            for (int k = 0; k < 9; k++) begin
                cm = i_cof[k][CW-1] ? CW'(-i_cof[k]) : CW'(i_cof[k]);
                nn = (NW'(cm) << (2 * FRAC_BITS + 1)) + NW'(w_dm);
                r_ng[0][k] <= i_cof[k][CW-1] ^ i_det[DW-1];
                top = nn >> QB;
                // high part beyond the quotient window: overflow if >= divisor
                r_ovf[0][k] <= top >= NW'(RW'(w_dm) << 1);
                r_rem[0][k] <= RW'(top);
                r_num[0][k] <= nn[QB-1:0];
                r_q[0][k]   <= '0;
            end
            for (int s = 1; s < NS; s++) begin
                r_sg[s] <= r_sg[s-1];
                r_dv[s] <= r_dv[s-1];
                for (int k = 0; k < 9; k++) begin
                    t = {r_rem[s-1][k][RW-2:0], r_num[s-1][k][QB-s]};
                    r_ng[s][k]  <= r_ng[s-1][k];
                    r_ovf[s][k] <= r_ovf[s-1][k];
                    r_num[s][k] <= r_num[s-1][k];
                    if (t >= r_dv[s-1]) begin
                        r_rem[s][k] <= t - r_dv[s-1];
                        r_q[s][k]   <= {r_q[s-1][k][QB-2:0], 1'b1};
                    end else begin
                        r_rem[s][k] <= t;
                        r_q[s][k]   <= {r_q[s-1][k][QB-2:0], 1'b0};
                    end
                end
            end
            r_os <= r_sg[NS-1];
            for (int k = 0; k < 9; k++) begin
                if (r_sg[NS-1])
                    r_or[k] <= '0;
                else if (r_ng[NS-1][k]) begin
                    if (r_ovf[NS-1][k] || r_q[NS-1][k] > QB'({1'b1, {(ELEM_WIDTH-1){1'b0}}}))
                        r_or[k] <= {1'b1, {(ELEM_WIDTH-1){1'b0}}};
                    else
                        r_or[k] <= ELEM_WIDTH'(-r_q[NS-1][k]);
                end else begin
                    if (r_ovf[NS-1][k] || r_q[NS-1][k] > QB'({1'b0, {(ELEM_WIDTH-1){1'b1}}}))
                        r_or[k] <= {1'b0, {(ELEM_WIDTH-1){1'b1}}};
                    else
                        r_or[k] <= ELEM_WIDTH'(r_q[NS-1][k]);
                end
            end
        end
    end
endmodule

// ===== sim/matrix_inverse_3x3_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top_tb
// self-checking bench for the 3x3 fixed-point matrix inverse
// ----------------------------------------------------------------------------
// Matrices are queued by the stimulus process and offered in random bursts.
// Each accepted matrix is inverted here with wide exact integer arithmetic
// (adjugate, determinant, rounded and saturated quotient). Each accepted
// inverse is compared field by field against the oldest prediction. The
// threshold register is rewritten between phases while the block is drained,
// and the receiver stalls randomly, once for a long stretch.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_top_tb;
    import mi3_pkg::*;

    localparam int EW         = ELEM_WIDTH_DEF;
    localparam int FB         = FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam logic signed [EW-1:0] ONE  = 1 <<< FB;
    localparam logic signed [EW-1:0] EMAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic signed [EW-1:0] EMIN = {1'b1, {(EW-1){1'b0}}};

    typedef logic signed [EW-1:0] t_elem;
    typedef struct {
        t_elem e[NUM_ELEMS];
    } t_matrix;
    typedef struct {
        t_elem r[NUM_ELEMS];
        logic  singular;
    } t_inverse;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [THR_WIDTH-1:0] i_singular_threshold = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_elem i_m[NUM_ELEMS] = '{default: '0};
    logic o_valid;
    logic i_ready = 1'b0;
    t_elem o_r[NUM_ELEMS];
    logic o_singular;

    t_matrix  pending_mats[$];
    t_inverse expected_invs[$];
    t_matrix  cur_mat;
    logic [THR_WIDTH-1:0] thr_now = '0;
    int errors = 0;
    int mats_accepted = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_cnt = 0;
    logic long_hold = 1'b0;

    always #6 i_clk = ~i_clk;

    matrix_inverse_3x3_top uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_singular_threshold (i_singular_threshold),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_m00 (i_m[0]), .i_m01 (i_m[1]), .i_m02 (i_m[2]),
        .i_m10 (i_m[3]), .i_m11 (i_m[4]), .i_m12 (i_m[5]),
        .i_m20 (i_m[6]), .i_m21 (i_m[7]), .i_m22 (i_m[8]),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_r00 (o_r[0]), .o_r01 (o_r[1]), .o_r02 (o_r[2]),
        .o_r10 (o_r[3]), .o_r11 (o_r[4]), .o_r12 (o_r[5]),
        .o_r20 (o_r[6]), .o_r21 (o_r[7]), .o_r22 (o_r[8]),
        .o_singular           (o_singular)
    );

    function automatic t_inverse invert_matrix(t_matrix m, logic [THR_WIDTH-1:0] thr);
        logic signed [127:0] a[NUM_ELEMS];
        logic signed [127:0] adj[NUM_ELEMS];
        logic signed [127:0] det;
        logic [127:0] det_mag, cof_mag, quo, lim;
        logic neg;
        t_inverse res;
        for (int i = 0; i < NUM_ELEMS; i++) begin
            a[i] = m.e[i];
        end
        adj[0] = a[4] * a[8] - a[5] * a[7];
        adj[1] = a[2] * a[7] - a[1] * a[8];
        adj[2] = a[1] * a[5] - a[2] * a[4];
        adj[3] = a[5] * a[6] - a[3] * a[8];
        adj[4] = a[0] * a[8] - a[2] * a[6];
        adj[5] = a[2] * a[3] - a[0] * a[5];
        adj[6] = a[3] * a[7] - a[4] * a[6];
        adj[7] = a[1] * a[6] - a[0] * a[7];
        adj[8] = a[0] * a[4] - a[1] * a[3];
        det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
        det_mag = (det < 0) ? -det : det;
        lim = {97'b0, thr} << (2 * FB);
        res.singular = (det_mag <= lim);
        for (int i = 0; i < NUM_ELEMS; i++) begin
            if (res.singular) begin
                res.r[i] = '0;
            end else begin
                neg = (adj[i] < 0) ^ (det < 0);
                cof_mag = (adj[i] < 0) ? -adj[i] : adj[i];
                quo = ((cof_mag << (2 * FB + 1)) + det_mag) / (det_mag << 1);
                if (neg) begin
                    res.r[i] = (quo > 128'(EMAX) + 1) ? EMIN : -quo[EW-1:0];
                end else begin
                    res.r[i] = (quo > 128'(EMAX)) ? EMAX : quo[EW-1:0];
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // sender: bursts with random gaps
    always @(posedge i_clk) begin
        logic nv;
        nv = i_valid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_invs.push_back(invert_matrix(cur_mat, thr_now));
                mats_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    nv = 1'b0;
                end else if (pending_mats.size() > 0) begin
                    cur_mat = pending_mats.pop_front();
                    for (int i = 0; i < NUM_ELEMS; i++) begin
                        i_m[i] <= cur_mat.e[i];
                    end
                    nv = 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    nv = 1'b0;
                end
            end
        end
        i_valid <= nv;
    end

    // receiver: stall pattern, result check and watchdog
    always @(posedge i_clk) begin
        t_inverse want;
        if (i_rst_n && ((i_valid && o_ready) || (i_cfg_valid && o_cfg_ready) ||
                        (o_valid && i_ready))) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("matrix_inverse_3x3_top_tb failed");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_invs.size() == 0) begin
                report_mismatch("unexpected item", {63'b0, o_singular}, '0);
            end else begin
                want = expected_invs.pop_front();
                for (int i = 0; i < NUM_ELEMS; i++) begin
                    if (o_r[i] !== want.r[i]) begin
                        report_mismatch($sformatf("r%0d%0d", i / 3, i % 3),
                                        64'(o_r[i]), 64'(want.r[i]));
                    end
                end
                if (o_singular !== want.singular) begin
                    report_mismatch("singular", {63'b0, o_singular},
                                    {63'b0, want.singular});
                end
            end
        end
        stall_cnt++;
        if (stall_cnt >= 150) begin
            stall_cnt = 0;
            stall_mode = $urandom_range(0, 2);
        end
        if (long_hold) begin
            i_ready <= 1'b0;
        end else if (stall_mode == 0) begin
            i_ready <= 1'b1;
        end else if (stall_mode == 1) begin
            i_ready <= 1'($urandom_range(0, 1));
        end else begin
            i_ready <= ($urandom_range(0, 9) != 0);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (mats_accepted >= 200);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    function automatic t_elem rand_elem();
        return $signed($urandom()) >>> $urandom_range(0, 30);
    endfunction

    function automatic t_matrix rand_matrix();
        t_matrix m;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < NUM_ELEMS; i++) begin
            if (kind < 5) begin
                m.e[i] = $signed(32'($urandom_range(0, 32'h2_0000))) - ONE;
                if (i % 4 == 0) m.e[i] = m.e[i] + (ONE <<< $urandom_range(0, 2));
            end else if (kind < 7) begin
                m.e[i] = rand_elem();
            end else begin
                m.e[i] = $urandom();
            end
        end
        if (kind == 9) begin
            for (int j = 0; j < 3; j++) begin
                m.e[6 + j] = m.e[j];
            end
        end
        return m;
    endfunction

    function automatic t_matrix diag_matrix(t_elem d0, t_elem d1, t_elem d2, t_elem off);
        t_matrix m;
        for (int i = 0; i < NUM_ELEMS; i++) begin
            m.e[i] = off;
        end
        m.e[0] = d0;
        m.e[4] = d1;
        m.e[8] = d2;
        return m;
    endfunction

    task automatic write_threshold(logic [THR_WIDTH-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_singular_threshold <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        thr_now = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_mats.size() > 0 || i_valid || expected_invs.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic queue_random(int count);
        for (int n = 0; n < count; n++) begin
            pending_mats.push_back(rand_matrix());
        end
    endtask

    initial begin
        t_matrix m;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_threshold('0);
        // identity, zero, scaled, extremes, near-singular and saturating cases
        pending_mats.push_back(diag_matrix(ONE, ONE, ONE, '0));
        pending_mats.push_back(diag_matrix('0, '0, '0, '0));
        pending_mats.push_back(diag_matrix(ONE <<< 1, ONE <<< 2, -ONE, '0));
        pending_mats.push_back(diag_matrix(EMAX, EMAX, EMAX, '0));
        pending_mats.push_back(diag_matrix(EMIN, EMIN, EMIN, '0));
        pending_mats.push_back(diag_matrix(EMIN, EMAX, EMIN, EMAX));
        pending_mats.push_back(diag_matrix(EMAX, EMAX, EMAX, EMAX));
        pending_mats.push_back(diag_matrix(EMIN, EMIN, EMIN, EMIN));
        pending_mats.push_back(diag_matrix(32'sd1, 32'sd1, 32'sd1, '0));
        pending_mats.push_back(diag_matrix(-32'sd1, 32'sd1, 32'sd1, '0));
        pending_mats.push_back(diag_matrix(32'sd3, 32'sd1, 32'sd1, '0));
        pending_mats.push_back(diag_matrix(ONE, ONE, ONE, ONE));
        pending_mats.push_back(diag_matrix(ONE <<< 8, ONE <<< 8, ONE <<< 8, '0));
        pending_mats.push_back(diag_matrix(ONE * 3, ONE * 3, ONE * 3, ONE));
        pending_mats.push_back(diag_matrix(-1, -1, -1, '0));
        pending_mats.push_back(diag_matrix(ONE, ONE, 32'sd1, '0));
        for (int i = 0; i < NUM_ELEMS; i++) m.e[i] = ONE * (i + 1);
        pending_mats.push_back(m);
        for (int i = 0; i < NUM_ELEMS; i++) m.e[i] = (i % 2) ? EMAX : EMIN;
        pending_mats.push_back(m);
        for (int i = 0; i < NUM_ELEMS; i++) m.e[i] = (i % 3 == 0) ? ONE : -ONE;
        m.e[4] = ONE * 2;
        pending_mats.push_back(m);
        queue_random(300);
        drain();

        write_threshold({THR_WIDTH{1'b1}});
        pending_mats.push_back(diag_matrix(EMIN, EMIN, EMIN, '0));
        pending_mats.push_back(diag_matrix(EMAX, EMAX, EMAX, '0));
        queue_random(40);
        drain();

        write_threshold(THR_WIDTH'(1));
        pending_mats.push_back(diag_matrix(ONE, ONE, ONE, '0));
        pending_mats.push_back(diag_matrix(ONE, ONE, ONE + 1, '0));
        queue_random(300);
        drain();

        write_threshold(THR_WIDTH'(ONE));
        pending_mats.push_back(diag_matrix(ONE, ONE, ONE, '0));
        pending_mats.push_back(diag_matrix(ONE, ONE, ONE + 1, '0));
        queue_random(300);
        drain();

        write_threshold(THR_WIDTH'($urandom()));
        queue_random(300);
        drain();

        write_threshold('0);
        queue_random(200);
        drain();

        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_invs.size() == 0) begin
            $display("matrix_inverse_3x3_top_tb passed");
        end else begin
            $display("matrix_inverse_3x3_top_tb failed");
        end
        $finish;
    end
endmodule
